// ===== rtl/core/cip_pkg.sv =====
package cip_pkg;

  localparam int VAL_W         = 26;
  localparam int POW_W         = 4;
  localparam int CLAMP_W       = 25;
  localparam int MAG_W         = 26;
  localparam int PROD_W        = 2 * MAG_W + 1;
  localparam int MAX_EXP_DEF   = 10;
  localparam int FRAC_BITS_DEF = 20;

  localparam logic [CLAMP_W-1:0] CLAMP_RESET = 25'd10485759;
  localparam logic [MAG_W-1:0]   MAG_LIMIT   = 26'd1 << (VAL_W - 1);
  localparam logic [MAG_W-1:0]   MAG_CAP     = MAG_LIMIT + 26'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } cip_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic exp_zero;
    logic exp_odd;
  } cip_cmd_t;

endpackage

// ===== rtl/core/clamped_integer_power.sv =====
// clamped integer power
// start/busy command channel: an item (base_value, power, last_in) is taken
// at a clock edge where start is high and busy is low. power saturates at
// MAX_EXP-1. the result (result_value, clamped, low_saturated, last_out) is
// shown for exactly one cycle with done high; the receiver cannot stall,
// so every result must be taken in that cycle.
// one shared rounding multiplier works one product per cycle, so an item
// with exponent p steps through ST_MUL for any products it needs and then
// ST_FIN, which registers the result and raises done; busy drops at that
// same edge, so a new item may be accepted while done is shown.
// clamp_limit is written on any edge with clamp_limit_we high; the user
// must write it only while the block is idle, which the block itself does
// not enforce. reset (rst, synchronous) returns the controller to idle,
// drops done and loads clamp_limit with about 9.999999 in Q5.20.
module clamped_integer_power #(
  parameter int MAX_EXP   = cip_pkg::MAX_EXP_DEF,
  parameter int FRAC_BITS = cip_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [cip_pkg::VAL_W-1:0] base_value,
  input  logic [cip_pkg::POW_W-1:0]        power,
  input  logic                             last_in,
  input  logic                             clamp_limit_we,
  input  logic [cip_pkg::CLAMP_W-1:0]      clamp_limit_wdata,
  output logic                             done,
  output logic signed [cip_pkg::VAL_W-1:0] result_value,
  output logic                             clamped,
  output logic                             low_saturated,
  output logic                             last_out
);
  import cip_pkg::*;

  cip_cmd_t cmd;

  cip_ctrl #(
    .MAX_EXP(MAX_EXP)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .power (power),
    .busy  (busy),
    .cmd   (cmd)
  );

  cip_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .base_value        (base_value),
    .last_in           (last_in),
    .clamp_limit_we    (clamp_limit_we),
    .clamp_limit_wdata (clamp_limit_wdata),
    .result_value      (result_value),
    .clamped           (clamped),
    .low_saturated     (low_saturated),
    .last_out          (last_out),
    .done              (done)
  );

endmodule

// ===== rtl/core/cip_ctrl.sv =====
module cip_ctrl #(
  parameter int MAX_EXP = cip_pkg::MAX_EXP_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [cip_pkg::POW_W-1:0] power,
  output logic                    busy,
  output cip_pkg::cip_cmd_t       cmd
);
  import cip_pkg::*;

  localparam int CNT_W = $clog2(MAX_EXP);

  cip_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] p_sat;
  logic             accept;

  // exponent saturates at the top of its range
  always_comb begin
    if (int'(power) > MAX_EXP - 1) begin
      p_sat = CNT_W'(MAX_EXP - 1);
    end else begin
      p_sat = power[CNT_W-1:0];
    end
  end

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (p_sat > CNT_W'(1)) ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = (p_sat == '0) ? '0 : p_sat - CNT_W'(1);
    end else if (state == ST_MUL) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.exp_zero = (p_sat == '0);
    cmd.exp_odd  = p_sat[0];
    unique case (state)
      ST_IDLE: cmd.load   = start;
      ST_MUL:  cmd.step   = 1'b1;
      ST_FIN:  cmd.finish = 1'b1;
      default: cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/cip_dp.sv =====
module cip_dp #(
  parameter int FRAC_BITS = cip_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cip_pkg::cip_cmd_t                cmd,
  input  logic signed [cip_pkg::VAL_W-1:0] base_value,
  input  logic                             last_in,
  input  logic                             clamp_limit_we,
  input  logic [cip_pkg::CLAMP_W-1:0]      clamp_limit_wdata,
  output logic signed [cip_pkg::VAL_W-1:0] result_value,
  output logic                             clamped,
  output logic                             low_saturated,
  output logic                             last_out,
  output logic                             done
);
  import cip_pkg::*;

  localparam logic [MAG_W-1:0]  ONE_VAL =
    (FRAC_BITS >= VAL_W - 1) ? (MAG_LIMIT - 26'd1) : (26'd1 << FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic [CLAMP_W-1:0] clamp_limit;
  logic [MAG_W-1:0]   mag, m, m_next;
  logic               neg, exp_zero, exp_odd, last_r;
  logic [PROD_W-1:0]  prod, rounded;
  logic [VAL_W-1:0]   raw, res;
  logic               res_clamped, res_lowsat, rneg;

  assign raw = base_value;

  // rounded magnitude product, capped just above the representable range
  always_comb begin
    prod    = PROD_W'(m) * PROD_W'(mag) + HALF;
    rounded = prod >> FRAC_BITS;
    m_next  = (rounded > PROD_W'(MAG_CAP)) ? MAG_CAP : rounded[MAG_W-1:0];
  end

  always_comb begin
    rneg        = neg && exp_odd && (m != '0);
    res         = '0;
    res_clamped = 1'b0;
    res_lowsat  = 1'b0;
    if (exp_zero) begin
      res = ONE_VAL;
    end else if (!rneg) begin
      if (m > MAG_W'(clamp_limit)) begin
        res         = VAL_W'(clamp_limit);
        res_clamped = 1'b1;
      end else begin
        res = m;
      end
    end else if (m > MAG_LIMIT) begin
      res        = MAG_LIMIT;
      res_lowsat = 1'b1;
    end else begin
      res = '0 - m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= CLAMP_RESET;
      done        <= 1'b0;
    end else begin
      if (clamp_limit_we) begin
        clamp_limit <= clamp_limit_wdata;
      end
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= raw[VAL_W-1];
      mag      <= raw[VAL_W-1] ? ('0 - raw) : raw;
      m        <= raw[VAL_W-1] ? ('0 - raw) : raw;
      exp_zero <= cmd.exp_zero;
      exp_odd  <= cmd.exp_odd;
      last_r   <= last_in;
    end else if (cmd.step) begin
      m <= m_next;
    end
    if (cmd.finish) begin
      result_value  <= res;
      clamped       <= res_clamped;
      low_saturated <= res_lowsat;
      last_out      <= last_r;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cip_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    clamped;
    logic                    low_sat;
    logic                    last;
  } power_result_t;

  class power_checker;
    power_result_t         expected_powers[$];
    logic [CLAMP_W-1:0]    limit;
    int unsigned           mismatches;

    function new();
      limit      = CLAMP_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(logic [CLAMP_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction

    // magnitude and sign kept apart, each product rounded half up
    function power_result_t predict_power(logic signed [VAL_W-1:0] b, logic [POW_W-1:0] p,
                                          logic l);
      logic [VAL_W-1:0]  raw_mag;
      longint unsigned   mag;
      longint unsigned   m;
      longint unsigned   half;
      int unsigned       exp_n;
      logic              neg;
      logic              rneg;
      power_result_t     r;
      neg     = b[VAL_W-1];
      raw_mag = neg ? (~b + VAL_W'(1)) : b;
      mag     = 64'(raw_mag);
      half    = 64'd1 << (FRAC_BITS_DEF - 1);
      exp_n   = (int'(p) > MAX_EXP_DEF - 1) ? MAX_EXP_DEF - 1 : int'(p);
      r.value   = '0;
      r.clamped = 1'b0;
      r.low_sat = 1'b0;
      r.last    = l;
      if (exp_n == 0) begin
        r.value = VAL_W'(64'd1 << FRAC_BITS_DEF);
      end else begin
        m = mag;
        for (int i = 1; i < exp_n; i++) begin
          m = (m * mag + half) >> FRAC_BITS_DEF;
          if (m > 64'(MAG_CAP)) m = 64'(MAG_CAP);
        end
        rneg = neg && exp_n[0] && (m != 0);
        if (!rneg) begin
          if (m > 64'(limit)) begin
            r.value   = VAL_W'(limit);
            r.clamped = 1'b1;
          end else begin
            r.value = VAL_W'(m);
          end
        end else if (m > 64'(MAG_LIMIT)) begin
          r.value   = MAG_LIMIT;
          r.low_sat = 1'b1;
        end else begin
          r.value = VAL_W'(64'd0 - m);
        end
      end
      return r;
    endfunction

    function void note_operand(logic signed [VAL_W-1:0] b, logic [POW_W-1:0] p, logic l);
      expected_powers.push_back(predict_power(b, p, l));
    endfunction

    function void check_result(power_result_t act);
      power_result_t exp_r;
      if (expected_powers.size() == 0) begin
        $error("result_value %0d with no item outstanding", act.value);
        mismatches++;
        return;
      end
      exp_r = expected_powers.pop_front();
      if (act.value !== exp_r.value) begin
        $error("result_value mismatch: expected %0d, got %0d", exp_r.value, act.value);
        mismatches++;
      end
      if (act.clamped !== exp_r.clamped) begin
        $error("clamped mismatch: expected %0b, got %0b", exp_r.clamped, act.clamped);
        mismatches++;
      end
      if (act.low_sat !== exp_r.low_sat) begin
        $error("low_saturated mismatch: expected %0b, got %0b", exp_r.low_sat, act.low_sat);
        mismatches++;
      end
      if (act.last !== exp_r.last) begin
        $error("last_out mismatch: expected %0b, got %0b", exp_r.last, act.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] base_value = '0;
  logic [POW_W-1:0]        power = '0;
  logic                    last_in = 1'b0;
  logic                    clamp_limit_we = 1'b0;
  logic [CLAMP_W-1:0]      clamp_limit_wdata = '0;
  logic                    done;
  logic signed [VAL_W-1:0] result_value;
  logic                    clamped;
  logic                    low_saturated;
  logic                    last_out;

  power_checker checker_h = new();

  always #2 clk = ~clk;

  clamped_integer_power u_top (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .base_value        (base_value),
    .power             (power),
    .last_in           (last_in),
    .clamp_limit_we    (clamp_limit_we),
    .clamp_limit_wdata (clamp_limit_wdata),
    .done              (done),
    .result_value      (result_value),
    .clamped           (clamped),
    .low_saturated     (low_saturated),
    .last_out          (last_out)
  );

  always @(posedge clk) begin
    power_result_t act;
    if (!rst) begin
      if (clamp_limit_we) checker_h.set_limit(clamp_limit_wdata);
      if (start && !busy) checker_h.note_operand(base_value, power, last_in);
      if (done) begin
        act.value   = result_value;
        act.clamped = clamped;
        act.low_sat = low_saturated;
        act.last    = last_out;
        checker_h.check_result(act);
      end
    end
  end

  // one beat, held until the block takes it
  task automatic drive_beat(input logic signed [VAL_W-1:0] b, input logic [POW_W-1:0] p,
                            input logic l);
    start      <= 1'b1;
    base_value <= b;
    power      <= p;
    last_in    <= l;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (checker_h.pending() != 0);
  endtask

  task automatic write_limit(input logic [CLAMP_W-1:0] v);
    repeat (12) @(posedge clk);
    clamp_limit_we    <= 1'b1;
    clamp_limit_wdata <= v;
    @(posedge clk);
    clamp_limit_we    <= 1'b0;
  endtask

  task automatic random_operand(output logic signed [VAL_W-1:0] b,
                                output logic [POW_W-1:0] p, output logic l);
    int   m;
    logic neg;
    neg = 1'($urandom_range(0, 1));
    m   = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: m = (1 << 20) + $urandom_range(0, 1 << 19) - (1 << 18);
      3, 4:    m = $urandom_range(0, (1 << 20) - 1);
      5:       m = $urandom_range(1 << 20, 1 << 22);
      6: begin
        case ($urandom_range(0, 4))
          0:       m = 1 << 25;
          1:       m = (1 << 25) - 1;
          2:       m = 0;
          3:       m = 1;
          default: m = 2 << 20;
        endcase
      end
      default: m = -1;
    endcase
    if (m < 0) b = VAL_W'($urandom);
    else       b = neg ? VAL_W'(-m) : VAL_W'(m);
    p = ($urandom_range(0, 6) == 0) ? POW_W'($urandom_range(10, 15))
                                    : POW_W'($urandom_range(0, 9));
    l = 1'($urandom_range(0, 1));
  endtask

  task automatic run_phase(input int n_items, input bit hold_mid);
    int                      sent;
    int                      burst;
    int                      gap;
    logic signed [VAL_W-1:0] b;
    logic [POW_W-1:0]        p;
    logic                    l;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        random_operand(b, p, l);
        drive_beat(b, p, l);
        sent++;
        if (hold_mid && sent == n_items / 2) drain();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) idle_for(gap);
    end
  endtask

  initial begin
    logic [CLAMP_W-1:0] limits [6];
    limits[0] = '1;
    limits[1] = '0;
    limits[2] = CLAMP_W'($urandom);
    limits[3] = CLAMP_W'(1 << 20);
    limits[4] = CLAMP_W'($urandom_range(0, 1 << 24));
    limits[5] = CLAMP_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // edge cases under the reset clamp
    drive_beat(26'sd0, 4'd0, 1'b0);
    drive_beat(26'sd0, 4'd1, 1'b1);
    drive_beat(26'sd0, 4'd3, 1'b0);
    drive_beat(26'sd1048576, 4'd0, 1'b1);
    drive_beat(-26'sd33554432, 4'd0, 1'b0);
    drive_beat(-26'sd33554432, 4'd1, 1'b1);
    drive_beat(-26'sd33554432, 4'd2, 1'b0);
    drive_beat(-26'sd33554432, 4'd3, 1'b1);
    drive_beat(26'sd33554431, 4'd1, 1'b0);
    drive_beat(26'sd33554431, 4'd9, 1'b1);
    drive_beat(-26'sd2097152, 4'd5, 1'b0);
    drive_beat(-26'sd2097152, 4'd7, 1'b1);
    drive_beat(26'sd2097152, 4'd3, 1'b0);
    drive_beat(26'sd2097152, 4'd4, 1'b1);
    drive_beat(26'sd24576, 4'd3, 1'b0);
    drive_beat(-26'sd24576, 4'd3, 1'b1);
    drive_beat(-26'sd1, 4'd1, 1'b0);
    drive_beat(-26'sd1, 4'd2, 1'b1);
    drive_beat(-26'sd1, 4'd3, 1'b0);
    drive_beat(26'sd524288, 4'd9, 1'b1);
    drive_beat(-26'sd3145728, 4'd15, 1'b0);
    drive_beat(26'sd1048577, 4'd12, 1'b1);
    drive_beat(-26'sd1572864, 4'd10, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      run_phase(150, ph == 1);
      drain();
    end

    repeat (20) @(posedge clk);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("clamped_integer_power test passed");
    end else begin
      $display("clamped_integer_power test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("clamped_integer_power test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cip_pkg.sv
rtl/core/cip_ctrl.sv
rtl/core/cip_dp.sv
rtl/core/clamped_integer_power.sv
tb/tb.sv
